>>> rtl/core/assert_macros.svh
// Assertion macros used by the RTL decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside of reset.
`define UPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define UPD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/core/upd_pkg.sv
`default_nettype none

package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Result queue depth and the width of its occupancy count.
  localparam int unsigned QDEPTH = 3;
  localparam int unsigned QCNT_W = 2;
  localparam int unsigned QIDX_W = 2;

  typedef enum logic [1:0] {
    ESC_IDLE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } esc_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic [7:0] plain_byte(input logic [7:0] c);
    return (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/url_percent_decoder.sv
`default_nettype none
`include "assert_macros.svh"

// URL form decoder: takes one encoded byte per cycle while in_ready is high
// and produces the decoded stream, turning '+' into a space and "%XY" into
// one byte. Each byte is decoded in the cycle it is accepted and lands in a
// three-entry result queue, so the first result is visible in the cycle after
// its input beat. Input and output each move one beat per cycle when not held
// by back-pressure; the output port's single beat per cycle sets the rate. A
// '%' one byte before the end of a string yields two result beats, while the
// two digit bytes of an escape yield one beat for two input beats. in_ready
// depends only on the queue fill, never combinationally on out_ready.
module url_percent_decoder
  import upd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            out_last
);

  esc_phase_t         phase_r, phase_nxt;
  logic [7:0]         first_r, first_nxt;
  res_t               q_r   [QDEPTH];
  res_t               q_nxt [QDEPTH];
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  logic               in_fire;
  logic               out_fire;
  logic [1:0]         res_cnt;
  res_t               res0;
  res_t               res1;
  hex_t               hi_hex;
  hex_t               lo_hex;
  logic [QIDX_W-1:0]  base;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Two free entries are needed before a beat may enter.
  assign in_ready  = (cnt_r <= QCNT_W'(1));
  assign out_valid = (cnt_r != '0);
  assign out_byte  = q_r[0].data;
  assign out_last  = q_r[0].last;

  assign hi_hex = hex_decode(first_r);
  assign lo_hex = hex_decode(in_byte);

  // Escape tracking.
  always_comb begin
    phase_nxt = phase_r;
    first_nxt = first_r;
    if (in_fire) begin
      unique case (phase_r)
        ESC_PCT: begin
          if (in_last) begin
            phase_nxt = ESC_IDLE;
          end else begin
            phase_nxt = ESC_DIGIT;
            first_nxt = in_byte;
          end
        end
        ESC_DIGIT: begin
          phase_nxt = ESC_IDLE;
        end
        default: begin
          phase_nxt = (in_byte == CH_PERCENT && !in_last) ? ESC_PCT : ESC_IDLE;
        end
      endcase
    end
  end

  // Results produced by the accepted beat.
  always_comb begin
    res_cnt   = 2'd0;
    res0.data = plain_byte(in_byte);
    res0.last = in_last;
    res1.data = plain_byte(in_byte);
    res1.last = 1'b1;
    if (in_fire) begin
      unique case (phase_r)
        ESC_PCT: begin
          if (in_last) begin
            res_cnt   = 2'd2;
            res0.data = CH_PERCENT;
            res0.last = 1'b0;
          end
        end
        ESC_DIGIT: begin
          res_cnt = 2'd1;
          if (!hi_hex.ok) begin
            res0.data = 8'h00;
          end else if (!lo_hex.ok) begin
            res0.data = {4'h0, hi_hex.val};
          end else begin
            res0.data = {hi_hex.val, lo_hex.val};
          end
        end
        default: begin
          if (!(in_byte == CH_PERCENT && !in_last)) begin
            res_cnt = 2'd1;
          end
        end
      endcase
    end
  end

  // Result queue: the head sits in entry 0, new results go behind the survivors.
  always_comb begin
    q_nxt = q_r;
    base  = cnt_r;
    if (out_fire) begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
        q_nxt[i] = q_r[i+1];
      end
      base = cnt_r - QIDX_W'(1);
    end
    if (res_cnt != 2'd0) begin
      q_nxt[base] = res0;
    end
    if (res_cnt == 2'd2) begin
      q_nxt[base + QIDX_W'(1)] = res1;
    end
    cnt_nxt = cnt_r - QCNT_W'(out_fire) + QCNT_W'(res_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ESC_IDLE;
      first_r <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      first_r <= first_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  `UPD_ASSERT_IMPL(a_two_only_pct_last, res_cnt == 2'd2, phase_r == ESC_PCT && in_last, "two results outside a short escape")
  `UPD_ASSERT(a_last_clears_escape, in_fire && in_last |=> phase_r == ESC_IDLE, "escape left pending after last beat")
  `UPD_ASSERT(a_pct_to_digit, in_fire && phase_r == ESC_PCT && !in_last |=> phase_r == ESC_DIGIT, "first digit byte not captured")
  `UPD_ASSERT(a_pop_only, out_fire && !in_fire |=> cnt_r == $past(cnt_r) - QCNT_W'(1), "queue count off after pop")

endmodule

`default_nettype wire
